// ===== hdl/ipv4hc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4hc_pkg: shared types and constants for the IPv4 receive header check
// Verdict codes, header byte positions and the result record passed from
// the header tracker to the top level.
// ----------------------------------------------------------------------------
package ipv4hc_pkg;

  typedef enum logic [2:0] {
    VERDICT_DELIVER_UDP = 3'd0,
    VERDICT_UNHANDLED   = 3'd1,
    VERDICT_SHORT       = 3'd2,
    VERDICT_BAD_VERSION = 3'd3,
    VERDICT_BAD_IHL     = 3'd4,
    VERDICT_BAD_CSUM    = 3'd5,
    VERDICT_NOT_FOR_US  = 3'd6
  } verdict_t;

  // header byte positions in wire order
  localparam int POS_VER_IHL   = 0;
  localparam int POS_TLEN_HI   = 2;
  localparam int POS_TLEN_LO   = 3;
  localparam int POS_PROTO     = 9;
  localparam int POS_CSUM_HI   = 10;
  localparam int POS_CSUM_LO   = 11;
  localparam int POS_SRC_FIRST = 12;
  localparam int POS_SRC_LAST  = 15;
  localparam int POS_DST_FIRST = 16;
  localparam int POS_DST_LAST  = 19;

  localparam int          MIN_HEADER   = 20;
  localparam logic [3:0]  IP_VERSION   = 4'd4;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [31:0] BCAST_ADDR   = 32'hFFFF_FFFF;

  localparam logic REG_LOCAL_ADDRESS = 1'b0;

  localparam int OUT_TDATA_W = 72;

  typedef struct packed {
    verdict_t     verdict;
    logic [31:0]  source_address;
    logic [7:0]   protocol_number;
    logic [5:0]   payload_offset;
    logic [16:0]  payload_length;
  } result_t;

endpackage

// ===== hdl/ipv4hc_hdr_track.sv =====
// ----------------------------------------------------------------------------
// ipv4hc_hdr_track: per-packet header capture and checksum
// Holds the byte count, running ones-complement sum and captured header
// fields; forms the verdict for the byte being taken when it ends a packet.
// ----------------------------------------------------------------------------
module ipv4hc_hdr_track #(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_take,
  input  logic [7:0]          byte_data,
  input  logic                byte_last,
  input  logic [31:0]         local_address,
  output ipv4hc_pkg::result_t result
);
  import ipv4hc_pkg::*;

  localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       hold_r, hold_nxt;
  logic [3:0]       version_r, version_nxt;
  logic [5:0]       hdr_bytes_r, hdr_bytes_nxt;
  logic [15:0]      tlen_r, tlen_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [31:0]      src_r, src_nxt;
  logic [31:0]      dst_r, dst_nxt;
  logic [15:0]      csum_r, csum_nxt;

  logic [CNT_W-1:0] pos;
  logic             pos_live;
  logic             in_header;
  logic [7:0]       sum_byte;
  logic [16:0]      sum_wide;
  logic [CMP_W-1:0] len_cmp;
  logic [CMP_W-1:0] hdr_cmp;

  assign pos      = count_r;
  assign pos_live = (pos < CNT_W'(MAX_PACKET_BYTES));

  always_comb begin
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    hold_nxt      = hold_r;
    version_nxt   = version_r;
    hdr_bytes_nxt = hdr_bytes_r;
    tlen_nxt      = tlen_r;
    proto_nxt     = proto_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    csum_nxt      = csum_r;
    in_header     = 1'b0;
    sum_byte      = byte_data;
    sum_wide      = '0;
    if (pos_live) begin
      count_nxt = pos + CNT_W'(1);
      if (pos == CNT_W'(POS_VER_IHL)) begin
        version_nxt   = byte_data[7:4];
        hdr_bytes_nxt = {byte_data[3:0], 2'b00};
      end else if (pos == CNT_W'(POS_TLEN_HI) || pos == CNT_W'(POS_TLEN_LO)) begin
        tlen_nxt = {tlen_r[7:0], byte_data};
      end else if (pos == CNT_W'(POS_PROTO)) begin
        proto_nxt = byte_data;
      end else if (pos == CNT_W'(POS_CSUM_HI) || pos == CNT_W'(POS_CSUM_LO)) begin
        csum_nxt = {csum_r[7:0], byte_data};
      end else if (pos >= CNT_W'(POS_SRC_FIRST) && pos <= CNT_W'(POS_SRC_LAST)) begin
        src_nxt = {src_r[23:0], byte_data};
      end else if (pos >= CNT_W'(POS_DST_FIRST) && pos <= CNT_W'(POS_DST_LAST)) begin
        dst_nxt = {dst_r[23:0], byte_data};
      end
      // header length comes from this very byte at the first position
      in_header = (CMP_W'(pos) < CMP_W'(hdr_bytes_nxt));
      // checksum field counts as zero
      if (pos == CNT_W'(POS_CSUM_HI) || pos == CNT_W'(POS_CSUM_LO)) begin
        sum_byte = 8'h00;
      end
      if (in_header) begin
        if (!pos[0]) begin
          hold_nxt = sum_byte;
        end else begin
          sum_wide = {1'b0, sum_r} + {1'b0, hold_r, sum_byte};
          sum_nxt  = sum_wide[16] ? (sum_wide[15:0] + 16'd1) : sum_wide[15:0];
        end
      end
    end
  end

  assign len_cmp = CMP_W'(count_nxt);
  assign hdr_cmp = CMP_W'(hdr_bytes_nxt);

  always_comb begin
    result = '0;
    if (len_cmp < CMP_W'(MIN_HEADER)) begin
      result.verdict = VERDICT_SHORT;
    end else if (version_nxt != IP_VERSION) begin
      result.verdict = VERDICT_BAD_VERSION;
    end else if (hdr_cmp < CMP_W'(MIN_HEADER) || hdr_cmp > len_cmp) begin
      result.verdict = VERDICT_BAD_IHL;
    end else if (~sum_nxt != csum_nxt) begin
      result.verdict = VERDICT_BAD_CSUM;
    end else if (dst_nxt != local_address && dst_nxt != BCAST_ADDR) begin
      result.verdict = VERDICT_NOT_FOR_US;
    end else begin
      result.verdict         = (proto_nxt == PROTO_UDP) ? VERDICT_DELIVER_UDP
                                                        : VERDICT_UNHANDLED;
      result.source_address  = src_nxt;
      result.protocol_number = proto_nxt;
      result.payload_offset  = hdr_bytes_nxt;
      result.payload_length  = {1'b0, tlen_nxt} - {11'b0, hdr_bytes_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_take && byte_last)) begin
      // start the next packet from a clean slate
      count_r     <= '0;
      sum_r       <= '0;
      hold_r      <= '0;
      version_r   <= '0;
      hdr_bytes_r <= '0;
      tlen_r      <= '0;
      proto_r     <= '0;
      src_r       <= '0;
      dst_r       <= '0;
      csum_r      <= '0;
    end else if (byte_take) begin
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      hold_r      <= hold_nxt;
      version_r   <= version_nxt;
      hdr_bytes_r <= hdr_bytes_nxt;
      tlen_r      <= tlen_nxt;
      proto_r     <= proto_nxt;
      src_r       <= src_nxt;
      dst_r       <= dst_nxt;
      csum_r      <= csum_nxt;
    end
  end

endmodule

// ===== hdl/ipv4_receive_header_check_core.sv =====
// ----------------------------------------------------------------------------
// ipv4_receive_header_check_core: IPv4 receive header check
// Streams a packet in byte by byte and returns one verdict per packet.
// ----------------------------------------------------------------------------
// Takes one packet byte per clock with no gaps required; every byte passes
// an input register and then the header tracker, whose checksum add and
// field compares close into the result register, so a verdict is registered
// there as the last byte leaves the input register. Non-final bytes never stall;
// the final byte waits in the input register only while an earlier verdict
// still sits unread in the result register. Bytes past MAX_PACKET_BYTES are
// counted as absent. All state is in flip-flops and needs no clearing pass.
module ipv4_receive_header_check_core #(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: [7:0] packet_byte
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,
  input  logic                               in_tlast,
  // out_tdata: [2:0] verdict, [34:3] source_address, [42:35] protocol_number,
  //            [48:43] payload_offset, [65:49] payload_length, [71:66] zero
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ipv4hc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [2:0]                         cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import ipv4hc_pkg::*;

  logic [31:0] local_addr_r;
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        out_valid_r;
  result_t     out_res_r;
  result_t     hdr_res;
  logic        out_free;
  logic        s1_adv;
  logic        out_load;
  logic        cfg_wr;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_LOCAL_ADDRESS) ? local_addr_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r <= '0;
    end else if (cfg_wr && cfg_paddr[2] == REG_LOCAL_ADDRESS) begin
      local_addr_r <= cfg_pwdata;
    end
  end

  // input register; a final byte advances only into a free result slot
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!s1_last_r || out_free);
  assign out_load  = s1_adv && s1_last_r;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  ipv4hc_hdr_track #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_hdr_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_take    (s1_adv),
    .byte_data    (s1_byte_r),
    .byte_last    (s1_last_r),
    .local_address(local_addr_r),
    .result       (hdr_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= hdr_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0,
                       out_res_r.payload_length,
                       out_res_r.payload_offset,
                       out_res_r.protocol_number,
                       out_res_r.source_address,
                       out_res_r.verdict};

  // a newly raised result is always preceded by a final byte leaving the input register
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && s1_last_r))
    else $error("result appeared without a final byte");

  // input stalls only behind a final byte
  a_stall_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_tready))
    else $error("input stalled without a pending final byte");

  // rejected packets carry no header details
  a_early_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.verdict != VERDICT_DELIVER_UDP &&
     out_res_r.verdict != VERDICT_UNHANDLED) |->
    (out_res_r.source_address == 32'd0 && out_res_r.protocol_number == 8'd0 &&
     out_res_r.payload_offset == 6'd0 && out_res_r.payload_length == 17'd0))
    else $error("rejected packet reports header fields");

endmodule

// ===== test/ipv4_receive_header_check_core_tb.sv =====
// ----------------------------------------------------------------------------
// ipv4_receive_header_check_core_tb: self-checking bench for the header check
// Streams IPv4 packets byte by byte under random gaps and output stalls,
// predicts the verdict record of every packet, and compares each result
// transfer field by field. The local address register is changed between
// phases: a directed phase, then random phases at several addresses.
// ----------------------------------------------------------------------------
module ipv4_receive_header_check_core_tb;
  import ipv4hc_pkg::*;

  localparam int         MAX_PACKET_BYTES = 2048;
  localparam int         LONG_HOLD        = 300;
  localparam int         WATCHDOG_LIMIT   = 2000;
  localparam int         DRAIN_LIMIT      = 1000;
  localparam int         SETTLE_CYCLES    = 6;
  localparam logic [2:0] LOCAL_ADDR_OFFSET = {REG_LOCAL_ADDRESS, 2'b00};
  localparam logic [2:0] UNUSED_OFFSET     = 3'd4;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } wire_byte_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata    = '0;
  logic                   in_tlast    = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [2:0]             cfg_paddr   = '0;
  logic [31:0]            cfg_pwdata  = '0;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  ipv4_receive_header_check_core #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // traffic and scoreboard state
  wire_byte_t  wire_bytes[$];
  result_t     expected_verdicts[$];
  int          bytes_outstanding = 0;
  int          bytes_queued      = 0;
  int          mismatch_count    = 0;
  int          results_taken     = 0;
  int          tx_gap            = 0;
  int          rx_wait           = 0;
  int          quiet_cycles      = 0;
  bit          tx_steady         = 1'b0;
  bit          rx_steady         = 1'b0;
  logic        in_acc            = 1'b0;
  logic        out_acc           = 1'b0;

  // header tracker copy
  logic [31:0] local_addr_cfg = '0;
  logic [11:0] rx_count;
  logic [16:0] csum_acc;
  logic [7:0]  hi_hold;
  logic [3:0]  seen_version;
  logic [5:0]  seen_hdr_len;
  logic [15:0] seen_total_len;
  logic [7:0]  seen_proto;
  logic [31:0] seen_src;
  logic [31:0] seen_dst;
  logic [15:0] seen_csum;

  function automatic void clear_packet_state();
    rx_count       = '0;
    csum_acc       = '0;
    hi_hold        = '0;
    seen_version   = '0;
    seen_hdr_len   = '0;
    seen_total_len = '0;
    seen_proto     = '0;
    seen_src       = '0;
    seen_dst       = '0;
    seen_csum      = '0;
  endfunction

  // Advance the header tracker by one byte; on the final byte queue the verdict.
  task automatic track_header_byte(input logic [7:0] b, input logic last);
    int          pos;
    logic [7:0]  w;
    logic [16:0] sum_next;
    result_t     r;
    pos = int'(rx_count);
    if (pos < MAX_PACKET_BYTES) begin
      if (pos == POS_VER_IHL) begin
        seen_version = b[7:4];
        seen_hdr_len = {b[3:0], 2'b00};
      end else if (pos == POS_TLEN_HI || pos == POS_TLEN_LO) begin
        seen_total_len = {seen_total_len[7:0], b};
      end else if (pos == POS_PROTO) begin
        seen_proto = b;
      end else if (pos == POS_CSUM_HI || pos == POS_CSUM_LO) begin
        seen_csum = {seen_csum[7:0], b};
      end else if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) begin
        seen_src = {seen_src[23:0], b};
      end else if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) begin
        seen_dst = {seen_dst[23:0], b};
      end
      if (pos < int'(seen_hdr_len)) begin
        // checksum field counts as zero in the sum
        w = (pos == POS_CSUM_HI || pos == POS_CSUM_LO) ? 8'h00 : b;
        if (rx_count[0] == 1'b0) begin
          hi_hold = w;
        end else begin
          sum_next = csum_acc + {hi_hold, w};
          csum_acc = (sum_next > 17'h0FFFF) ? {1'b0, sum_next[15:0]} + 17'd1 : sum_next;
        end
      end
      rx_count = rx_count + 12'd1;
    end
    if (last) begin
      r = '0;
      if (int'(rx_count) < MIN_HEADER) begin
        r.verdict = VERDICT_SHORT;
      end else if (seen_version != IP_VERSION) begin
        r.verdict = VERDICT_BAD_VERSION;
      end else if (int'(seen_hdr_len) < MIN_HEADER || int'(seen_hdr_len) > int'(rx_count)) begin
        r.verdict = VERDICT_BAD_IHL;
      end else if (~csum_acc[15:0] != seen_csum) begin
        r.verdict = VERDICT_BAD_CSUM;
      end else if (seen_dst != local_addr_cfg && seen_dst != BCAST_ADDR) begin
        r.verdict = VERDICT_NOT_FOR_US;
      end else begin
        r.verdict         = (seen_proto == PROTO_UDP) ? VERDICT_DELIVER_UDP : VERDICT_UNHANDLED;
        r.source_address  = seen_src;
        r.protocol_number = seen_proto;
        r.payload_offset  = seen_hdr_len;
        r.payload_length  = {1'b0, seen_total_len} - {11'd0, seen_hdr_len};
      end
      expected_verdicts.push_back(r);
      clear_packet_state();
    end
  endtask

  task automatic check_verdict(input logic [OUT_TDATA_W-1:0] d);
    result_t want;
    if (expected_verdicts.size() == 0) begin
      $error("unexpected result transfer, tdata %h", d);
      mismatch_count++;
    end else begin
      want = expected_verdicts.pop_front();
      if (d[2:0] !== want.verdict) begin
        $error("verdict: expected %0d, got %0d", want.verdict, d[2:0]);
        mismatch_count++;
      end
      if (d[34:3] !== want.source_address) begin
        $error("source_address: expected %h, got %h", want.source_address, d[34:3]);
        mismatch_count++;
      end
      if (d[42:35] !== want.protocol_number) begin
        $error("protocol_number: expected %0d, got %0d", want.protocol_number, d[42:35]);
        mismatch_count++;
      end
      if (d[48:43] !== want.payload_offset) begin
        $error("payload_offset: expected %0d, got %0d", want.payload_offset, d[48:43]);
        mismatch_count++;
      end
      if (d[65:49] !== want.payload_length) begin
        $error("payload_length: expected %h, got %h", want.payload_length, d[65:49]);
        mismatch_count++;
      end
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    in_acc  <= rst_n && in_tvalid && in_tready;
    out_acc <= rst_n && out_tvalid && out_tready;
    if (rst_n && out_tvalid && out_tready) check_verdict(out_tdata);
    if (rst_n && in_tvalid && in_tready) begin
      bytes_outstanding--;
      track_header_byte(in_tdata, in_tlast);
    end
  end

  // byte sender: hold the current byte until its transfer, then gap or advance
  always @(negedge clk) begin
    wire_byte_t cur;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_acc)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (wire_bytes.size() > 0) begin
        cur = wire_bytes.pop_front();
        in_tdata  <= cur.data;
        in_tlast  <= cur.last;
        in_tvalid <= 1'b1;
        tx_gap = tx_steady ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls, plus long hold-offs that back up the input
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_acc) begin
        results_taken++;
        if (results_taken == 8 || results_taken == 30) begin
          rx_wait = LONG_HOLD;
        end else begin
          rx_wait = rx_steady ? 0 : $urandom_range(0, 6);
        end
        if ($urandom_range(0, 29) == 0) rx_steady = !rx_steady;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_register(input logic [2:0] offset, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= offset;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (offset == LOCAL_ADDR_OFFSET) local_addr_cfg = value;
  endtask

  task automatic check_local_address();
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= LOCAL_ADDR_OFFSET;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== local_addr_cfg) begin
      $error("local_address: expected %h, got %h", local_addr_cfg, cfg_prdata);
      mismatch_count++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic send_packet_bytes(ref logic [7:0] pkt[$]);
    wire_byte_t wb;
    int         i;
    for (i = 0; i < pkt.size(); i++) begin
      wb.data = pkt[i];
      wb.last = (i == pkt.size() - 1);
      wire_bytes.push_back(wb);
    end
    bytes_outstanding += pkt.size();
    bytes_queued      += pkt.size();
  endtask

  // Build a header with a correct checksum unless told otherwise; tot_len < 0
  // means ihl * 4 plus body_len, cut_len > 0 truncates the packet.
  task automatic queue_packet(input logic [3:0] ver, input logic [3:0] ihl, input int body_len,
                              input int tot_len, input logic [7:0] proto,
                              input logic [31:0] dst, input bit bad_csum, input int cut_len);
    logic [7:0]  pkt[$];
    logic [15:0] tl;
    logic [16:0] s;
    logic [15:0] csum;
    int          hdr_n;
    int          i;
    hdr_n = (int'(ihl) * 4 < MIN_HEADER) ? MIN_HEADER : int'(ihl) * 4;
    for (i = 0; i < hdr_n + body_len; i++) pkt.push_back(8'($urandom_range(0, 255)));
    tl = (tot_len < 0) ? 16'(int'(ihl) * 4 + body_len) : 16'(tot_len);
    pkt[POS_VER_IHL] = {ver, ihl};
    pkt[POS_TLEN_HI] = tl[15:8];
    pkt[POS_TLEN_LO] = tl[7:0];
    pkt[POS_PROTO]   = proto;
    pkt[POS_CSUM_HI] = 8'h00;
    pkt[POS_CSUM_LO] = 8'h00;
    for (i = 0; i < 4; i++) pkt[POS_DST_FIRST + i] = dst[31 - 8 * i -: 8];
    s = '0;
    for (i = 0; i + 1 < int'(ihl) * 4; i += 2) begin
      s = s + {pkt[i], pkt[i + 1]};
      if (s > 17'h0FFFF) s = {1'b0, s[15:0]} + 17'd1;
    end
    csum = ~s[15:0];
    if (bad_csum) csum = csum ^ 16'($urandom_range(1, 65535));
    pkt[POS_CSUM_HI] = csum[15:8];
    pkt[POS_CSUM_LO] = csum[7:0];
    if (cut_len > 0) begin
      while (pkt.size() > cut_len) void'(pkt.pop_back());
    end
    send_packet_bytes(pkt);
  endtask

  task automatic queue_noise(input int len);
    logic [7:0] pkt[$];
    int         i;
    for (i = 0; i < len; i++) pkt.push_back(8'($urandom_range(0, 255)));
    send_packet_bytes(pkt);
  endtask

  // Let all bytes transfer and all verdicts arrive before touching the register.
  task automatic wait_until_drained();
    int waited;
    waited = 0;
    while (bytes_outstanding != 0) @(negedge clk);
    while (expected_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_random_phase(input int budget);
    int          start;
    int          kind;
    int          body;
    int          tl;
    int          cut;
    int          pick;
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [31:0] dst;
    bit          bad;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      kind  = $urandom_range(0, 99);
      ihl   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
      body  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 12);
      tl    = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535)) : -1;
      proto = ($urandom_range(0, 4) < 3) ? PROTO_UDP : 8'($urandom_range(0, 255));
      pick  = $urandom_range(0, 3);
      dst   = (pick < 2) ? local_addr_cfg : (pick == 2) ? BCAST_ADDR : $urandom;
      ver   = IP_VERSION;
      bad   = 1'b0;
      cut   = 0;
      if (kind < 55) begin
        // well-formed header
      end else if (kind < 65) begin
        bad = 1'b1;
      end else if (kind < 73) begin
        ver = 4'($urandom_range(0, 15));
      end else if (kind < 81) begin
        if ($urandom_range(0, 1) == 0) begin
          ihl = 4'($urandom_range(0, 4));
        end else begin
          ihl = 4'($urandom_range(6, 15));
          cut = $urandom_range(MIN_HEADER, int'(ihl) * 4 - 1);
        end
      end else if (kind < 90) begin
        cut = $urandom_range(1, MIN_HEADER - 1);
      end
      if (kind >= 90) queue_noise($urandom_range(1, 40));
      else queue_packet(ver, ihl, body, tl, proto, dst, bad, cut);
    end
    wait_until_drained();
  endtask

  initial begin
    clear_packet_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_register(LOCAL_ADDR_OFFSET, 32'hC0A8_0A05);
    write_register(UNUSED_OFFSET, 32'h0BAD_F00D);
    check_local_address();

    // directed packets
    queue_noise(1);
    queue_packet(IP_VERSION, 4'd5, 0, -1, PROTO_UDP, local_addr_cfg, 1'b0, MIN_HEADER - 1);
    queue_packet(4'd6, 4'd5, 4, -1, PROTO_UDP, local_addr_cfg, 1'b0, 0);
    queue_packet(IP_VERSION, 4'd4, 4, -1, PROTO_UDP, local_addr_cfg, 1'b0, 0);
    queue_packet(IP_VERSION, 4'd15, 0, -1, PROTO_UDP, local_addr_cfg, 1'b0, 24);
    queue_packet(IP_VERSION, 4'd5, 2, -1, PROTO_UDP, local_addr_cfg, 1'b1, 0);
    queue_packet(IP_VERSION, 4'd5, 2, -1, PROTO_UDP, 32'h0A00_0001, 1'b0, 0);
    queue_packet(IP_VERSION, 4'd5, 0, -1, PROTO_UDP, local_addr_cfg, 1'b0, 0);
    queue_packet(IP_VERSION, 4'd5, 3, -1, 8'd6, BCAST_ADDR, 1'b0, 0);
    // total length below the header length
    queue_packet(IP_VERSION, 4'd6, 1, 10, PROTO_UDP, local_addr_cfg, 1'b0, 0);
    queue_packet(IP_VERSION, 4'd15, 5, 16'hFFFF, 8'hFF, BCAST_ADDR, 1'b0, 0);
    wait_until_drained();

    write_register(LOCAL_ADDR_OFFSET, 32'h0000_0000);
    check_local_address();
    run_random_phase(300);

    write_register(LOCAL_ADDR_OFFSET, 32'hFFFF_FFFF);
    check_local_address();
    run_random_phase(300);

    write_register(LOCAL_ADDR_OFFSET, $urandom);
    check_local_address();
    run_random_phase(330);

    if (expected_verdicts.size() != 0) begin
      $error("%0d verdicts never arrived", expected_verdicts.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
